// ===== rtl/pgdb_pkg.sv =====
// Shared types, constants and step functions for the per-pixel depth background block.
package pgdb_pkg;

    localparam int CNT_W    = 11;
    localparam int SUM_W    = 26;
    localparam int SQS_W    = 42;
    localparam int PIX_W    = 19;
    localparam int DEPTH_W  = 16;
    localparam int RES_W    = 20;
    localparam int MULT_W   = 12;
    localparam int SQ_STEPS = 31;   // root bits of a 62-bit radicand
    localparam int DV_STEPS = 31;   // quotient bits
    localparam int RAD_W    = 62;
    localparam int SREM_W   = 34;
    localparam logic [MULT_W-1:0] MULT_RESET = 12'd256;

    typedef enum logic [1:0] {
        CMD_ACC   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum;
        logic [SQS_W-1:0] sqs;
    } t_entry;

    typedef struct packed {
        logic [RAD_W-1:0]    v;
        logic [SREM_W-1:0]   rem;
        logic [SQ_STEPS-1:0] root;
    } t_sq;

    typedef struct packed {
        logic [DV_STEPS-1:0] dvd;
        logic [CNT_W-1:0]    rem;
        logic [DV_STEPS-1:0] q;
    } t_dv;

    // one root bit of the digit-by-digit square root
    function automatic t_sq sq_step(t_sq x);
        logic [SREM_W+1:0] r2;
        logic [SREM_W+1:0] trial;
        t_sq y;
        r2    = {x.rem, x.v[RAD_W-1:RAD_W-2]};
        trial = (SREM_W+2)'({x.root, 2'b01});
        y.v   = {x.v[RAD_W-3:0], 2'b00};
        if (r2 >= trial) begin
            y.rem  = SREM_W'(r2 - trial);
            y.root = {x.root[SQ_STEPS-2:0], 1'b1};
        end else begin
            y.rem  = SREM_W'(r2);
            y.root = {x.root[SQ_STEPS-2:0], 1'b0};
        end
        return y;
    endfunction

    // one quotient bit of restoring division by an 11-bit divisor
    function automatic t_dv dv_step(t_dv x, logic [CNT_W-1:0] n);
        logic [CNT_W:0] t;
        t_dv y;
        t     = {x.rem, x.dvd[DV_STEPS-1]};
        y.dvd = {x.dvd[DV_STEPS-2:0], 1'b0};
        if (t >= {1'b0, n}) begin
            y.rem = CNT_W'(t - {1'b0, n});
            y.q   = {x.q[DV_STEPS-2:0], 1'b1};
        end else begin
            y.rem = t[CNT_W-1:0];
            y.q   = {x.q[DV_STEPS-2:0], 1'b0};
        end
        return y;
    endfunction

    function automatic logic [RES_W-1:0] sat20(logic [DV_STEPS-1:0] v);
        return (|v[DV_STEPS-1:RES_W]) ? {RES_W{1'b1}} : v[RES_W-1:0];
    endfunction

endpackage

// ===== rtl/per_pixel_gaussian_depth_background.sv =====
// Per-pixel depth background statistics. Each pixel keeps count, sum and sum of squares in
// one on-chip RAM. One command word is taken per clock unless input is stalled; accumulate
// and clear are a read-modify-write through the RAM with one-entry forwarding, so the same
// pixel may be hit on consecutive cycles. A read-out passes the product registers, a
// 31-stage square root (mean division alongside), a 31-stage division of the root by the
// count, band scaling and the output register. The whole pipeline freezes only while a
// finished result sits in the output register and the sink stalls. After reset the RAM
// is zeroed, one entry per clock, stalling input; configuration is taken at any time.
module per_pixel_gaussian_depth_background
    import pgdb_pkg::*;
#(
    parameter int PIXELS     = 524288,
    parameter int MAX_FRAMES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic [PIX_W-1:0]   i_pixel_index,
    input  logic [DEPTH_W-1:0] i_depth_mm,
    input  logic               i_depth_valid,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [MULT_W-1:0]  i_stdev_multiple,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [PIX_W-1:0]   o_out_pixel,
    output logic [RES_W-1:0]   o_mean_q4,
    output logic [RES_W-1:0]   o_stdev_q4,
    output logic [RES_W-1:0]   o_band_low_q4,
    output logic [RES_W-1:0]   o_band_high_q4,
    output logic [CNT_W-1:0]   o_sample_count,
    output logic               o_empty_pixel
);

    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAMES);

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [CNT_W-1:0] n;
        t_sq              sq;
        t_dv              dv;
    } t_pa;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [CNT_W-1:0] n;
        logic [RES_W-1:0] mean;
        t_dv              dv;
    } t_pb;

    // config
    logic [MULT_W-1:0] r_mult;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= MULT_RESET;
        end else if (i_cfg_valid) begin
            r_mult <= i_stdev_multiple;
        end
    end

    // clearing sweep
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    logic r_out_valid;
    logic adv;
    logic in_acc;
    assign adv        = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_clearing || !adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    logic [PIX_W:0] pix_ext;
    logic [AW-1:0]  in_addr;
    logic           in_range;
    assign pix_ext  = {1'b0, i_pixel_index};
    assign in_addr  = AW'(pix_ext);
    assign in_range = (21'(pix_ext) < 21'(PIXELS));

    // read-modify-write stage
    logic                   r_s0_v;
    t_cmd                   r_s0_cmd;
    logic [PIX_W-1:0]       r_s0_pix;
    logic [AW-1:0]          r_s0_addr;
    logic                   r_s0_rng;
    logic                   r_s0_dv;
    logic [DEPTH_W-1:0]     r_s0_depth;
    logic [2*DEPTH_W-1:0]   r_s0_dsq;
    logic                   r_s0_hit;
    t_entry                 r_fwd;
    t_entry                 rdata;
    t_entry                 cur;
    t_entry                 upd;
    logic                   item_we;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    t_entry                 ram_wdata;

    assign cur = r_s0_hit ? r_fwd : rdata;

    always_comb begin
        item_we = 1'b0;
        upd     = '0;
        if (adv && r_s0_v && r_s0_rng) begin
            case (r_s0_cmd)
                CMD_ACC: begin
                    if (r_s0_dv && (cur.cnt < MAX_CNT)) begin
                        item_we  = 1'b1;
                        upd.cnt  = cur.cnt + 1'b1;
                        upd.sum  = cur.sum + SUM_W'(r_s0_depth);
                        upd.sqs  = cur.sqs + SQS_W'(r_s0_dsq);
                    end
                end
                CMD_CLEAR: item_we = 1'b1;
                default:   item_we = 1'b0;
            endcase
        end
    end

    assign ram_we    = r_clearing || item_we;
    assign ram_waddr = r_clearing ? r_clr_addr : r_s0_addr;
    assign ram_wdata = r_clearing ? t_entry'('0) : upd;

    pgdb_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (PIXELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (adv),
        .i_raddr (in_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (adv) begin
            r_s0_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_we) begin
            r_fwd <= upd;
        end
        if (adv) begin
            r_s0_cmd   <= t_cmd'(i_command);
            r_s0_pix   <= i_pixel_index;
            r_s0_addr  <= in_addr;
            r_s0_rng   <= in_range;
            r_s0_dv    <= i_depth_valid;
            r_s0_depth <= i_depth_mm;
            r_s0_dsq   <= i_depth_mm * i_depth_mm;
            r_s0_hit   <= item_we && (r_s0_addr == in_addr);
        end
    end

    // read-out: products
    logic                 rd_go;
    logic [CNT_W-1:0]     rd_n;
    logic [SUM_W-1:0]     rd_s;
    logic [SQS_W-1:0]     rd_q;
    assign rd_go = r_s0_v && (r_s0_cmd == CMD_READ);
    assign rd_n  = r_s0_rng ? cur.cnt : '0;
    assign rd_s  = r_s0_rng ? cur.sum : '0;
    assign rd_q  = r_s0_rng ? cur.sqs : '0;

    logic               r_m1_v;
    logic [PIX_W-1:0]   r_m1_pix;
    logic [CNT_W-1:0]   r_m1_n;
    logic [SUM_W-1:0]   r_m1_s;
    logic [31:0]        r_m1_lo;
    logic [31:0]        r_m1_hi;
    logic [2*SUM_W-1:0] r_m1_ss;

    logic               r_m2_v;
    logic [PIX_W-1:0]   r_m2_pix;
    logic [CNT_W-1:0]   r_m2_n;
    logic [SUM_W-1:0]   r_m2_s;
    logic [52:0]        r_m2_d;
    logic [52:0]        m_a;
    logic [52:0]        m_b;

    assign m_a = 53'(r_m1_lo) + {r_m1_hi[31:0], 21'b0};
    assign m_b = 53'(r_m1_ss);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
        end else if (adv) begin
            r_m1_v <= rd_go;
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m1_pix <= r_s0_pix;
            r_m1_n   <= rd_n;
            r_m1_s   <= rd_s;
            r_m1_lo  <= rd_n * rd_q[20:0];
            r_m1_hi  <= rd_n * rd_q[41:21];
            r_m1_ss  <= rd_s * rd_s;
            r_m2_pix <= r_m1_pix;
            r_m2_n   <= r_m1_n;
            r_m2_s   <= r_m1_s;
            r_m2_d   <= (m_a > m_b) ? (m_a - m_b) : '0;
        end
    end

    // square root with mean division alongside, then root / count
    t_pa  r_pa   [0:SQ_STEPS];
    logic r_pa_v [0:SQ_STEPS];
    t_pb  r_pb   [0:DV_STEPS];
    logic r_pb_v [0:DV_STEPS];
    t_pa  pa_in;
    t_pb  pb_in;

    always_comb begin
        pa_in.pix     = r_m2_pix;
        pa_in.n       = r_m2_n;
        pa_in.sq.v    = RAD_W'({r_m2_d, 8'b0});
        pa_in.sq.rem  = '0;
        pa_in.sq.root = '0;
        pa_in.dv.dvd  = DV_STEPS'({r_m2_s, 4'b0});
        pa_in.dv.rem  = '0;
        pa_in.dv.q    = '0;
        pb_in.pix     = r_pa[SQ_STEPS].pix;
        pb_in.n       = r_pa[SQ_STEPS].n;
        pb_in.mean    = sat20(r_pa[SQ_STEPS].dv.q);
        pb_in.dv.dvd  = r_pa[SQ_STEPS].sq.root;
        pb_in.dv.rem  = '0;
        pb_in.dv.q    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQ_STEPS; k++) r_pa_v[k] <= 1'b0;
            for (int k = 0; k <= DV_STEPS; k++) r_pb_v[k] <= 1'b0;
        end else if (adv) begin
            r_pa_v[0] <= r_m2_v;
            for (int k = 0; k < SQ_STEPS; k++) r_pa_v[k+1] <= r_pa_v[k];
            r_pb_v[0] <= r_pa_v[SQ_STEPS];
            for (int k = 0; k < DV_STEPS; k++) r_pb_v[k+1] <= r_pb_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pa[0] <= pa_in;
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_pa[k+1].pix <= r_pa[k].pix;
                r_pa[k+1].n   <= r_pa[k].n;
                r_pa[k+1].sq  <= sq_step(r_pa[k].sq);
                r_pa[k+1].dv  <= dv_step(r_pa[k].dv, r_pa[k].n);
            end
            r_pb[0] <= pb_in;
            for (int k = 0; k < DV_STEPS; k++) begin
                r_pb[k+1].pix  <= r_pb[k].pix;
                r_pb[k+1].n    <= r_pb[k].n;
                r_pb[k+1].mean <= r_pb[k].mean;
                r_pb[k+1].dv   <= dv_step(r_pb[k].dv, r_pb[k].n);
            end
        end
    end

    // band scaling and output word
    logic                      r_c1_v;
    logic [PIX_W-1:0]          r_c1_pix;
    logic [CNT_W-1:0]          r_c1_n;
    logic [RES_W-1:0]          r_c1_mean;
    logic [RES_W-1:0]          r_c1_sd;
    logic [RES_W+MULT_W-1:0]   r_c1_prod;
    logic [RES_W-1:0]          c1_sd;
    logic [RES_W+MULT_W-9:0]   delta;
    logic [RES_W+MULT_W-8:0]   hi_sum;
    logic                      c1_empty;

    assign c1_sd    = sat20(r_pb[DV_STEPS].dv.q);
    assign delta    = r_c1_prod[RES_W+MULT_W-1:8];
    assign hi_sum   = 25'(r_c1_mean) + 25'(delta);
    assign c1_empty = (r_c1_n == '0);

    logic [PIX_W-1:0] r_out_pix;
    logic [RES_W-1:0] r_out_mean;
    logic [RES_W-1:0] r_out_sd;
    logic [RES_W-1:0] r_out_lo;
    logic [RES_W-1:0] r_out_hi;
    logic [CNT_W-1:0] r_out_cnt;
    logic             r_out_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_c1_v      <= r_pb_v[DV_STEPS];
            r_out_valid <= r_c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c1_pix  <= r_pb[DV_STEPS].pix;
            r_c1_n    <= r_pb[DV_STEPS].n;
            r_c1_mean <= r_pb[DV_STEPS].mean;
            r_c1_sd   <= c1_sd;
            r_c1_prod <= c1_sd * r_mult;
            r_out_pix   <= r_c1_pix;
            r_out_empty <= c1_empty;
            r_out_cnt   <= r_c1_n;
            if (c1_empty) begin
                r_out_mean <= '0;
                r_out_sd   <= '0;
                r_out_lo   <= '0;
                r_out_hi   <= '0;
            end else begin
                r_out_mean <= r_c1_mean;
                r_out_sd   <= r_c1_sd;
                r_out_lo   <= (24'(r_c1_mean) > delta) ? RES_W'(24'(r_c1_mean) - delta) : '0;
                r_out_hi   <= (|hi_sum[24:RES_W]) ? {RES_W{1'b1}} : hi_sum[RES_W-1:0];
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_pixel    = r_out_pix;
    assign o_mean_q4      = r_out_mean;
    assign o_stdev_q4     = r_out_sd;
    assign o_band_low_q4  = r_out_lo;
    assign o_band_high_q4 = r_out_hi;
    assign o_sample_count = r_out_cnt;
    assign o_empty_pixel  = r_out_empty;

    a_no_item_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !item_we)
        else $error("item write during clearing sweep");

    a_sweep_covers_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> $past(r_clr_addr) == LAST_ADDR)
        else $error("clearing sweep ended early");

    a_empty_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> (r_out_cnt == '0 && r_out_mean == '0
            && r_out_sd == '0 && r_out_hi == '0))
        else $error("empty pixel with nonzero result");

    a_band_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_lo <= r_out_mean && r_out_mean <= r_out_hi))
        else $error("band does not bracket mean");

    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_s0_v) && $stable(r_c1_v))
        else $error("pipeline moved while frozen");

endmodule

// ===== rtl/pgdb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module pgdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
